// ===== design/tabe_pkg.sv =====
// Tilt angle blend estimator package: word types, controller states,
// datapath command struct, fixed-point constants and the CORDIC angle table.
// Used by tabe_ctrl, tabe_dp and tilt_angle_blend_estimator.
`default_nettype none

package tabe_pkg;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [23:0] gyro_x;
		logic signed [23:0] gyro_y;
	} tabe_in_t;

	typedef struct packed {
		logic signed [23:0] angle_x;
		logic signed [23:0] angle_y;
	} tabe_out_t;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int STEP_W           = 5;
	localparam int SQRT_STEPS       = 24;
	localparam int DIV_STEPS        = 1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_STEP_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_SAMPLES = 2'd2;

	localparam logic [15:0] BLEND_WEIGHT_RST   = 16'd6554;
	localparam logic [31:0] GYRO_STEP_GAIN_RST = 32'd327862;
	localparam logic [9:0]  WARMUP_SAMPLES_RST = 10'd100;

	localparam logic signed [34:0] PI_Q30  = 35'sd3373259426;
	localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;
	localparam logic signed [23:0] OUT_MAX = 24'sh7F_FFFF;
	localparam logic signed [23:0] OUT_MIN = 24'sh80_0000;

	// radians Q2.30 -> degrees Q16: q = (|z|*9000 + den/2) / den, den = 157*2^14
	// done as ((...) >> 14) * (ceil(2^39/157) + 1) >> 39, exact below 2^31
	localparam logic [21:0] DEN_HALF  = 22'd1286144;
	localparam logic [13:0] DEG_MUL   = 14'd9000;
	localparam logic [31:0] DIV_RECIP = 32'd3501629389;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_ACC,
		S_SQRT,
		S_CINIT,
		S_CORDIC,
		S_DINIT,
		S_DIV,
		S_BMUL,
		S_BSUM,
		S_DONE
	} tabe_state_t;

	typedef struct packed {
		logic              load;
		logic              prep;
		logic              acc;
		logic              sqrt_step;
		logic              cordic_init;
		logic              cordic_step;
		logic              div_init;
		logic              div_step;
		logic              blend_mul;
		logic              blend_sum;
		logic              push;
		logic [STEP_W-1:0] step;
	} tabe_cmd_t;

	// atan(2^-i) in Q2.30 radians
	function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== design/tabe_ctrl.sv =====
// Controller for the tilt estimator: sequences warm-up, gyro integration,
// square root, CORDIC, degree conversion and blend. Depends on tabe_pkg.
`default_nettype none

module tabe_ctrl #(
	parameter int CORDIC_STEPS = tabe_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             sample_valid,
	output logic                  sample_ready,
	output logic                  result_valid,
	input  wire logic             result_ready,
	input  wire logic [9:0]       warmup_samples,
	output tabe_pkg::tabe_cmd_t   cmd
);
	import tabe_pkg::*;

	localparam logic [STEP_W-1:0] SQRT_LAST   = STEP_W'(SQRT_STEPS - 1);
	localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(CORDIC_STEPS - 1);
	localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(DIV_STEPS - 1);

	tabe_state_t       state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [9:0]        warm_q;
	logic              out_valid_q;
	logic              accept;
	logic              warm_run;

	assign sample_ready = (state_q == S_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign warm_run     = (warm_q >= warmup_samples);
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			warm_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (accept && !warm_run) begin
				warm_q <= warm_q + 10'd1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = '0;
		cmd      = '0;
		cmd.step = step_q;
		cmd.load = accept;
		unique case (state_q)
			S_IDLE: begin
				if (accept && warm_run) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (step_q == SQRT_LAST) begin
					state_d = S_CINIT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_CINIT: begin
				cmd.cordic_init = 1'b1;
				state_d         = S_CORDIC;
			end
			S_CORDIC: begin
				cmd.cordic_step = 1'b1;
				if (step_q == CORDIC_LAST) begin
					state_d = S_DINIT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == DIV_LAST) begin
					state_d = S_BMUL;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_BMUL: begin
				cmd.blend_mul = 1'b1;
				state_d       = S_BSUM;
			end
			S_BSUM: begin
				cmd.blend_sum = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || result_ready) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || result_ready))
		else $error("result word overwritten while stalled");

	a_warm_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !warm_run) |=> (warm_q == 10'($past(warm_q) + 10'd1)))
		else $error("warm-up count did not advance");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside of hand-off state");
`endif

endmodule

`default_nettype wire

// ===== design/tabe_dp.sv =====
// Datapath for the tilt estimator: gyro integrators, iterative square root,
// two CORDIC lanes, two reciprocal-multiply degree converters, blend and result.
// Depends on tabe_pkg; driven by tabe_ctrl commands.
`default_nettype none

module tabe_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tabe_pkg::tabe_cmd_t  cmd,
	input  wire tabe_pkg::tabe_in_t   sample,
	input  wire logic [15:0]          blend_weight,
	input  wire logic [31:0]          gyro_step_gain,
	output tabe_pkg::tabe_out_t       result
);
	import tabe_pkg::*;

	tabe_in_t           smp_q;
	logic signed [56:0] gprod_q [2];
	logic signed [47:0] acc_q   [2];
	logic [47:0]        sqv_q, sqr_q, sqb_q;
	logic signed [26:0] cx_q    [2];
	logic signed [26:0] cy_q    [2];
	logic signed [34:0] cz_q    [2];
	logic               czero_q [2];
	logic [31:0]        dn_q    [2];
	logic [24:0]        dq_q    [2];
	logic               dneg_q  [2];
	logic signed [56:0] p1_q    [2];
	logic signed [43:0] p2_q    [2];
	logic signed [23:0] res_q   [2];
	tabe_out_t          out_q;

	logic signed [23:0] gin     [2];
	logic signed [56:0] gprod   [2];
	logic signed [47:0] acc_n   [2];
	logic signed [26:0] xi      [2];
	logic signed [26:0] yi      [2];
	logic signed [26:0] cx_n    [2];
	logic signed [26:0] cy_n    [2];
	logic signed [34:0] cz_n    [2];
	logic signed [34:0] cz_i    [2];
	logic [31:0]        dn_i    [2];
	logic [24:0]        dq_n    [2];
	logic signed [56:0] p1      [2];
	logic signed [43:0] p2      [2];
	logic signed [23:0] res_n   [2];
	logic [31:0]        ay2, az2, sq_sum;
	logic [47:0]        sq_t;
	logic [16:0]        wc;

	assign ay2    = 32'(smp_q.accel_y * smp_q.accel_y);
	assign az2    = 32'(smp_q.accel_z * smp_q.accel_z);
	assign sq_sum = ay2 + az2;
	assign sq_t   = sqr_q + sqb_q;
	assign gin[0] = smp_q.gyro_x;
	assign gin[1] = smp_q.gyro_y;
	assign wc     = 17'h10000 - {1'b0, blend_weight};

	assign xi[0] = $signed({3'b000, sqr_q[23:0]});
	assign yi[0] = $signed({{3{smp_q.accel_x[15]}}, smp_q.accel_x, 8'h00});
	assign xi[1] = $signed({{3{smp_q.accel_z[15]}}, smp_q.accel_z, 8'h00});
	assign yi[1] = $signed({{3{smp_q.accel_y[15]}}, smp_q.accel_y, 8'h00});

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			logic signed [48:0] ginc;
			logic signed [49:0] asum;
			logic signed [26:0] xs, ys;
			logic signed [34:0] at;
			logic [32:0]        mag;
			logic signed [25:0] a16;
			logic signed [39:0] g16;
			logic signed [57:0] bsum;
			logic signed [33:0] bsh;

			gprod[i] = gin[i] * $signed({1'b0, gyro_step_gain});

			ginc = $signed(gprod_q[i][56:8]);
			asum = 50'(acc_q[i]) + 50'(ginc);
			if (asum > 50'(ACC_MAX)) begin
				acc_n[i] = ACC_MAX;
			end else if (asum < 50'(ACC_MIN)) begin
				acc_n[i] = ACC_MIN;
			end else begin
				acc_n[i] = asum[47:0];
			end

			xs = cx_q[i] >>> cmd.step;
			ys = cy_q[i] >>> cmd.step;
			at = $signed(35'(atan_q30(cmd.step)));
			if (cy_q[i] >= 0) begin
				cx_n[i] = cx_q[i] + ys;
				cy_n[i] = cy_q[i] - xs;
				cz_n[i] = cz_q[i] + at;
			end else begin
				cx_n[i] = cx_q[i] - ys;
				cy_n[i] = cy_q[i] + xs;
				cz_n[i] = cz_q[i] - at;
			end

			cz_i[i] = (yi[i] >= 0) ? PI_Q30 : -PI_Q30;

			mag = cz_q[i][34] ? 33'(-cz_q[i]) : cz_q[i][32:0];
			if (czero_q[i]) begin
				mag = '0;
			end
			dn_i[i] = 32'((46'(mag * DEG_MUL) + 46'(DEN_HALF)) >> 14);
			dq_n[i] = 25'((64'(dn_q[i]) * 64'(DIV_RECIP)) >> 39);

			a16   = dneg_q[i] ? -$signed({1'b0, dq_q[i]}) : $signed({1'b0, dq_q[i]});
			g16   = $signed(acc_q[i][47:8]);
			p1[i] = $signed({1'b0, blend_weight}) * g16;
			p2[i] = $signed({1'b0, wc}) * a16;

			bsum = 58'(p1_q[i]) + 58'(p2_q[i]) + 58'sh80_0000;
			bsh  = bsum[57:24];
			if (bsh > 34'(OUT_MAX)) begin
				res_n[i] = OUT_MAX;
			end else if (bsh < 34'(OUT_MIN)) begin
				res_n[i] = OUT_MIN;
			end else begin
				res_n[i] = bsh[23:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.acc) begin
			for (int i = 0; i < 2; i++) begin
				acc_q[i] <= acc_n[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smp_q <= sample;
		end
		if (cmd.prep) begin
			sqv_q <= {sq_sum, 16'h0000};
			sqr_q <= '0;
			sqb_q <= 48'd1 << 46;
		end
		if (cmd.sqrt_step) begin
			if (sqv_q >= sq_t) begin
				sqv_q <= sqv_q - sq_t;
				sqr_q <= (sqr_q >> 1) + sqb_q;
			end else begin
				sqr_q <= sqr_q >> 1;
			end
			sqb_q <= sqb_q >> 2;
		end
		for (int i = 0; i < 2; i++) begin
			if (cmd.prep) begin
				gprod_q[i] <= gprod[i];
			end
			if (cmd.cordic_init) begin
				czero_q[i] <= (xi[i] == 0) && (yi[i] == 0);
				if (xi[i] < 0) begin
					cx_q[i] <= -xi[i];
					cy_q[i] <= -yi[i];
					cz_q[i] <= cz_i[i];
				end else begin
					cx_q[i] <= xi[i];
					cy_q[i] <= yi[i];
					cz_q[i] <= '0;
				end
			end
			if (cmd.cordic_step) begin
				cx_q[i] <= cx_n[i];
				cy_q[i] <= cy_n[i];
				cz_q[i] <= cz_n[i];
			end
			if (cmd.div_init) begin
				dn_q[i]   <= dn_i[i];
				dneg_q[i] <= cz_q[i][34] && !czero_q[i];
			end
			if (cmd.div_step) begin
				dq_q[i] <= dq_n[i];
			end
			if (cmd.blend_mul) begin
				p1_q[i] <= p1[i];
				p2_q[i] <= p2[i];
			end
			if (cmd.blend_sum) begin
				res_q[i] <= res_n[i];
			end
		end
		if (cmd.push) begin
			out_q.angle_x <= res_q[0];
			out_q.angle_y <= res_q[1];
		end
	end

	assign result = out_q;

endmodule

`default_nettype wire

// ===== design/tilt_angle_blend_estimator.sv =====
// Tilt angle blend estimator top level: configuration registers and the
// controller / datapath pair. Depends on tabe_pkg, tabe_ctrl, tabe_dp.
//
// Usage:
//   sample channel (sample_valid/sample_ready/sample) takes one sensor word:
//   accelerometer x/y/z and gyro x/y rates. The first warmup_samples words
//   are only counted and give no result. Each later word gives one result
//   word (blended pitch and roll, signed Q16.8 degrees) on the result channel.
//   cfg channel writes blend_weight (0), gyro_step_gain (1) and
//   warmup_samples (2); other indexes are ignored. cfg_ready is always high.
//   After a non-warm-up word is accepted, the controller runs the 24-step
//   square root, the CORDIC_STEPS-step CORDIC lanes, a reciprocal multiply
//   for the degree conversion and seven other single steps, then raises
//   result_valid. A warm-up word leaves the controller idle. One word is
//   in work at a time: sample_ready is high only when idle.
//   The result register holds a finished word while result_ready is low; the
//   next word is accepted meanwhile and waits in its last step for the slot.
//   Reset clears the warm-up count and the gyro integrators and loads
//   the register defaults; no result is pending after reset.
`default_nettype none

module tilt_angle_blend_estimator #(
	parameter int CORDIC_STEPS = tabe_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sample_valid,
	output logic                                   sample_ready,
	input  wire tabe_pkg::tabe_in_t                sample,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output tabe_pkg::tabe_out_t                    result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tabe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [31:0]                       cfg_data
);
	import tabe_pkg::*;

	logic [15:0] blend_weight_q;
	logic [31:0] gyro_step_gain_q;
	logic [9:0]  warmup_samples_q;
	tabe_cmd_t   cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_weight_q   <= BLEND_WEIGHT_RST;
			gyro_step_gain_q <= GYRO_STEP_GAIN_RST;
			warmup_samples_q <= WARMUP_SAMPLES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BLEND_WEIGHT:   blend_weight_q   <= cfg_data[15:0];
				CFG_GYRO_STEP_GAIN: gyro_step_gain_q <= cfg_data;
				CFG_WARMUP_SAMPLES: warmup_samples_q <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	tabe_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.warmup_samples(warmup_samples_q),
		.cmd           (cmd)
	);

	tabe_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sample        (sample),
		.blend_weight  (blend_weight_q),
		.gyro_step_gain(gyro_step_gain_q),
		.result        (result)
	);

endmodule

`default_nettype wire

// ===== sim/tb_tilt_angle_blend_estimator.sv =====
// Testbench for tilt_angle_blend_estimator: random and directed sensor words with a
// bit-exact tilt predictor in a scoreboard class, across several register settings.
// Depends on tabe_pkg and the tilt_angle_blend_estimator RTL.
`default_nettype none

module tb_tilt_angle_blend_estimator;
	import tabe_pkg::*;

	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam longint LIMIT = 1500000;

	class tilt_board;
		logic [15:0] weight;
		logic [31:0] gain;
		logic [9:0]  warm_lim;
		logic [9:0]  warm_cnt;
		longint      gacc_x, gacc_y;
		tabe_out_t   pending[$];
		int          errors, checked;

		function void init();
			weight = BLEND_WEIGHT_RST;
			gain = GYRO_STEP_GAIN_RST;
			warm_lim = WARMUP_SAMPLES_RST;
			warm_cnt = '0;
			gacc_x = 0;
			gacc_y = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
			case (idx)
				CFG_BLEND_WEIGHT:   weight = d[15:0];
				CFG_GYRO_STEP_GAIN: gain = d;
				CFG_WARMUP_SAMPLES: warm_lim = d[9:0];
				default: ;
			endcase
		endfunction

		function longint fdiv(longint v, int s);
			return v >>> s;
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function longint root(longint v);
			longint r, b;
			r = 0;
			b = 64'sd1 <<< 62;
			while (b > v) b = b >>> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >>> 1) + b;
				end else begin
					r = r >>> 1;
				end
				b = b >>> 2;
			end
			return r;
		endfunction

		function longint atan2_deg(longint y, longint x);
			longint z, xs, ys, m, q;
			z = 0;
			if (x == 0 && y == 0) return 0;
			if (x < 0) begin
				z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
				x = -x;
				y = -y;
			end
			for (int i = 0; i < STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + longint'(atan_q30(i[STEP_W-1:0]));
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - longint'(atan_q30(i[STEP_W-1:0]));
				end
			end
			m = (z < 0 ? -z : z) * 9000;
			q = (m + 1286144) / 2572288;
			return z < 0 ? -q : q;
		endfunction

		function longint mix(longint acc, longint a16);
			longint g, w, s;
			g = fdiv(acc, 8);
			w = longint'(weight);
			s = w * g + (65536 - w) * a16;
			return clip(fdiv(s + (64'sd1 <<< 23), 24), OUT_MIN, OUT_MAX);
		endfunction

		function void note_sample(tabe_in_t s);
			longint ax, ay, az, gx, gy, pitch, roll;
			tabe_out_t r;
			if (warm_cnt < warm_lim) begin
				warm_cnt++;
				return;
			end
			ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
			gx = s.gyro_x; gy = s.gyro_y;
			pitch = atan2_deg(ax * 256, root((ay * ay + az * az) <<< 16));
			roll = atan2_deg(ay * 256, az * 256);
			gacc_x = clip(gacc_x + fdiv(gx * longint'(gain), 8), ACC_MIN, ACC_MAX);
			gacc_y = clip(gacc_y + fdiv(gy * longint'(gain), 8), ACC_MIN, ACC_MAX);
			r.angle_x = 24'(mix(gacc_x, pitch));
			r.angle_y = 24'(mix(gacc_y, roll));
			pending.push_back(r);
		endfunction

		function void check_result(tabe_out_t got);
			tabe_out_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected word %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.angle_x !== e.angle_x) begin
				$display("%0t angle_x exp %0d got %0d", $time, e.angle_x, got.angle_x);
				errors++;
			end
			if (got.angle_y !== e.angle_y) begin
				$display("%0t angle_y exp %0d got %0d", $time, e.angle_y, got.angle_y);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic sample_valid, sample_ready, result_valid, result_ready;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	tabe_in_t sample;
	tabe_out_t result;

	tilt_board board;
	int send_idle, recv_stall, n_sent;
	longint cycles;

	tilt_angle_blend_estimator u_top (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) board.check_result(result);
			result_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// valid stays up between back-to-back words; drain drops it
	task automatic send(tabe_in_t s);
		while ($urandom_range(99) < send_idle) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!sample_ready);
		board.note_sample(s);
		n_sent++;
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic tabe_in_t rand_sample();
		tabe_in_t s;
		s = tabe_in_t'({$urandom, $urandom, $urandom});
		case ($urandom_range(3))
			0: begin
				s.accel_x = $signed(16'($urandom_range(8000))) - 16'sd4000;
				s.accel_y = $signed(16'($urandom_range(8000))) - 16'sd4000;
				s.gyro_x = $signed(24'($urandom_range(20000))) - 24'sd10000;
				s.gyro_y = $signed(24'($urandom_range(20000))) - 24'sd10000;
			end
			1: s.accel_y = 0;
			default: ;
		endcase
		return s;
	endfunction

	task automatic directed();
		tabe_in_t s;
		logic signed [15:0] v[5] = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1};
		s = '0;
		send(s);
		for (int i = 0; i < 5; i++) begin
			s.accel_x = v[i];
			s.accel_y = v[(i + 1) % 5];
			s.accel_z = v[(i + 2) % 5];
			s.gyro_x = (i % 2) ? 24'sh7FFFFF : 24'sh800000;
			s.gyro_y = (i % 2) ? 24'sh800000 : 24'sh7FFFFF;
			send(s);
		end
		// negative z: half-turn start, with y zero and nonzero
		s = '0; s.accel_z = -16'sd1000; send(s);
		s.accel_y = -16'sd5; send(s);
		s.accel_y = 16'sd5; send(s);
		s = '0; s.accel_x = -16'sd300; send(s);
		s = '1; send(s);
	endtask

	initial begin
		int phase_items;
		board = new();
		board.init();
		cycles = 0;
		n_sent = 0;
		send_idle = 0;
		recv_stall = 0;
		arst_n = 0;
		sample_valid = 0;
		sample = '0;
		result_ready = 0;
		cfg_valid = 0;
		cfg_index = CFG_BLEND_WEIGHT;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short warm-up at the default settings
		write_cfg(CFG_WARMUP_SAMPLES, 32'd3);
		directed();
		drain();
		write_cfg(CFG_BLEND_WEIGHT, 32'hFFFF);
		write_cfg(CFG_GYRO_STEP_GAIN, 32'hFFFF_FFFF);
		directed();
		drain();
		write_cfg(CFG_BLEND_WEIGHT, 32'h0);
		write_cfg(CFG_GYRO_STEP_GAIN, 32'h0);
		write_cfg(CFG_WARMUP_SAMPLES, 32'd0);
		write_cfg(2'd3, 32'h1234);
		directed();
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin send_idle = 51; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 51; end
				3: begin send_idle = 31; recv_stall = 31; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			write_cfg(CFG_BLEND_WEIGHT, $urandom);
			write_cfg(CFG_GYRO_STEP_GAIN, (ph == 4) ? 32'hFFFF_FFFF : $urandom >> $urandom_range(20));
			// warm-up raised above the count: later words counted again until it is reached
			write_cfg(CFG_WARMUP_SAMPLES, (ph == 4) ? 32'h3FF : 32'(n_sent % 1024 + $urandom_range(3)));
			phase_items = (ph == 4) ? 30 : 90;
			for (int i = 0; i < phase_items; i++) send(rand_sample());
			drain();
		end

		$display("Sent %0d sensor words, checked %0d results over several register settings.",
			n_sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
